// ----- sv/dmsp_pkg.sv -----
// ============================================================================
// DNS message stream parser package
// Shared result codes, the descriptor that passes from the classifier to
// the result expander, and the queue sizing constants.
// ============================================================================
package dmsp_pkg;

   // Result kinds as they appear on the result stream.
   typedef enum logic [4:0] {
      FK_ID          = 5'd0,
      FK_QR          = 5'd1,
      FK_OPCODE      = 5'd2,
      FK_AA          = 5'd3,
      FK_TC          = 5'd4,
      FK_RD          = 5'd5,
      FK_RA          = 5'd6,
      FK_Z           = 5'd7,
      FK_RCODE       = 5'd8,
      FK_QDCOUNT     = 5'd9,
      FK_ANCOUNT     = 5'd10,
      FK_NSCOUNT     = 5'd11,
      FK_ARCOUNT     = 5'd12,
      FK_LABEL_LEN   = 5'd13,
      FK_NAME_BYTE   = 5'd14,
      FK_NAME_END    = 5'd15,
      FK_TYPE        = 5'd16,
      FK_CLASS       = 5'd17,
      FK_TTL         = 5'd18,
      FK_RDLENGTH    = 5'd19,
      FK_RDATA_BYTE  = 5'd20,
      FK_NONE        = 5'd21
   } field_kind_type;

   typedef enum logic [1:0] {
      ST_PARSING   = 2'd0,
      ST_COMPLETE  = 2'd1,
      ST_TRUNCATED = 2'd2,
      ST_TRAILING  = 2'd3
   } parse_status_type;

   // Section codes; the record sections follow the question section in order.
   localparam logic [2:0] SEC_HEADER   = 3'd0;
   localparam logic [2:0] SEC_QUESTION = 3'd1;

   // The flag word expands into this many results.
   localparam int FLAG_COUNT = 8;
   localparam logic [2:0] FLAG_LAST = 3'(FLAG_COUNT - 1);

   // Descriptor queue between classifier and expander.
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam int RSP_TDATA_W = 56;

   // One descriptor per input byte that produces results. A flag descriptor
   // carries both flag bytes in the low 16 bits of value.
   typedef struct packed {
      logic             flags;
      field_kind_type   kind;
      logic [31:0]      value;
      logic [2:0]       section;
      logic [15:0]      record;
      parse_status_type status;
   } desc_type;

endpackage

// ----- sv/dmsp_fifo.sv -----
// ============================================================================
// Descriptor queue
// Small register queue that decouples the byte classifier from the result
// expander.
// ============================================================================
module dmsp_fifo import dmsp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   output logic     full,
   input  logic     pop,
   output desc_type head,
   output logic     empty
);

   desc_type            mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full    = (cnt_ff == QCNT_W'(QDEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("descriptor pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("descriptor popped from an empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QDEPTH)) else $error("queue count exceeds its depth");

endmodule

// ----- sv/dmsp_front.sv -----
// ============================================================================
// Byte classifier
// Walks the message grammar one byte per cycle while the queue has room and
// keeps the parse state; every byte that produces results becomes one descriptor.
// ============================================================================
module dmsp_front import dmsp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  logic [7:0] req_tdata,
   input  logic     req_tlast,
   output logic     push,
   output desc_type push_desc,
   input  logic     q_full
);

   typedef enum logic [3:0] {
      PH_ID, PH_FLAGS, PH_QD, PH_AN, PH_NS, PH_AR, PH_LEN, PH_LABEL, PH_PTR,
      PH_TYPE, PH_CLASS, PH_TTL, PH_RDLEN, PH_RDATA, PH_DONE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  bwf_ff, bwf_in;
   logic [23:0] acc_ff, acc_in;
   logic [15:0] remain_ff [4];
   logic [15:0] remain_in [4];
   logic [15:0] record_ff, record_in;
   logic [7:0]  label_left_ff, label_left_in;
   logic [7:0]  label_cnt_ff, label_cnt_in;
   logic [15:0] rdata_left_ff, rdata_left_in;

   logic             fire;
   logic [7:0]       b;
   logic [31:0]      word;
   logic [2:0]       bwf_plus;
   logic             done2, done4;
   logic             in_records;
   logic [2:0]       sec;
   logic [15:0]      rec;
   logic             emit, is_flags, rec_end, fin_chk, hit_one, any_left;
   field_kind_type   kind;
   logic [31:0]      value;
   parse_status_type status;
   logic [7:0]       label_less;
   logic [15:0]      rdata_less;

   assign req_tready = !q_full;
   assign fire       = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign word       = {acc_ff, b};
   assign bwf_plus   = {1'b0, bwf_ff} + 3'd1;
   assign done2      = (bwf_plus >= 3'd2);
   assign done4      = (bwf_plus >= 3'd4);
   assign in_records = (phase_ff >= PH_LEN) && (phase_ff <= PH_RDATA);
   assign label_less = label_left_ff - 8'd1;
   assign rdata_less = rdata_left_ff - 16'd1;

   // Current section: first one with records left, only inside the body.
   always_comb begin
      sec = SEC_HEADER;
      if (in_records) begin
         if (remain_ff[0] != '0) begin
            sec = 3'd1;
         end else if (remain_ff[1] != '0) begin
            sec = 3'd2;
         end else if (remain_ff[2] != '0) begin
            sec = 3'd3;
         end else if (remain_ff[3] != '0) begin
            sec = 3'd4;
         end
      end
   end
   assign rec = (sec != SEC_HEADER) ? record_ff : 16'd0;

   always_comb begin
      phase_in      = phase_ff;
      bwf_in        = bwf_ff;
      acc_in        = acc_ff;
      remain_in     = remain_ff;
      record_in     = record_ff;
      label_left_in = label_left_ff;
      label_cnt_in  = label_cnt_ff;
      rdata_left_in = rdata_left_ff;
      emit          = 1'b0;
      is_flags      = 1'b0;
      kind          = FK_NONE;
      value         = '0;
      rec_end       = 1'b0;
      fin_chk       = 1'b0;
      hit_one       = 1'b0;
      any_left      = 1'b0;

      case (phase_ff)
         PH_ID, PH_FLAGS, PH_QD, PH_AN, PH_NS, PH_AR, PH_TYPE, PH_CLASS,
         PH_RDLEN: begin
            acc_in = {acc_ff[15:0], b};
            bwf_in = done2 ? 2'd0 : bwf_plus[1:0];
            if (done2) begin
               emit  = 1'b1;
               value = {16'd0, word[15:0]};
               case (phase_ff)
                  PH_ID: begin
                     kind     = FK_ID;
                     phase_in = PH_FLAGS;
                  end
                  PH_FLAGS: begin
                     kind     = FK_QR;
                     is_flags = 1'b1;
                     phase_in = PH_QD;
                  end
                  PH_QD: begin
                     kind         = FK_QDCOUNT;
                     remain_in[0] = word[15:0];
                     phase_in     = PH_AN;
                  end
                  PH_AN: begin
                     kind         = FK_ANCOUNT;
                     remain_in[1] = word[15:0];
                     phase_in     = PH_NS;
                  end
                  PH_NS: begin
                     kind         = FK_NSCOUNT;
                     remain_in[2] = word[15:0];
                     phase_in     = PH_AR;
                  end
                  PH_AR: begin
                     kind         = FK_ARCOUNT;
                     remain_in[3] = word[15:0];
                     record_in    = '0;
                     fin_chk      = 1'b1;
                  end
                  PH_TYPE: begin
                     kind     = FK_TYPE;
                     phase_in = PH_CLASS;
                  end
                  PH_CLASS: begin
                     kind = FK_CLASS;
                     if (sec == SEC_QUESTION) begin
                        rec_end = 1'b1;
                     end else begin
                        phase_in = PH_TTL;
                     end
                  end
                  PH_RDLEN: begin
                     kind          = FK_RDLENGTH;
                     rdata_left_in = word[15:0];
                     if (word[15:0] == '0) begin
                        rec_end = 1'b1;
                     end else begin
                        phase_in = PH_RDATA;
                     end
                  end
                  default: begin
                     kind = FK_NONE;
                  end
               endcase
            end
         end
         PH_TTL: begin
            acc_in = {acc_ff[15:0], b};
            bwf_in = done4 ? 2'd0 : bwf_plus[1:0];
            if (done4) begin
               emit     = 1'b1;
               kind     = FK_TTL;
               value    = word;
               phase_in = PH_RDLEN;
            end
         end
         PH_LEN: begin
            if (b == 8'h00) begin
               emit     = 1'b1;
               kind     = FK_NAME_END;
               value    = {24'd0, label_cnt_ff};
               phase_in = PH_TYPE;
               bwf_in   = 2'd0;
            end else if (b[7:6] == 2'b11) begin
               phase_in = PH_PTR;
            end else begin
               emit          = 1'b1;
               kind          = FK_LABEL_LEN;
               value         = {24'd0, b};
               label_left_in = b;
               phase_in      = PH_LABEL;
               if (label_cnt_ff != 8'hFF) begin
                  label_cnt_in = label_cnt_ff + 8'd1;
               end
            end
         end
         PH_LABEL: begin
            emit          = 1'b1;
            kind          = FK_NAME_BYTE;
            value         = {24'd0, b};
            label_left_in = label_less;
            if (label_less == '0) begin
               phase_in = PH_LEN;
            end
         end
         PH_PTR: begin
            emit     = 1'b1;
            kind     = FK_NAME_END;
            value    = {24'd0, label_cnt_ff};
            phase_in = PH_TYPE;
            bwf_in   = 2'd0;
         end
         PH_RDATA: begin
            emit          = 1'b1;
            kind          = FK_RDATA_BYTE;
            value         = {24'd0, b};
            rdata_left_in = rdata_less;
            if (rdata_less == '0) begin
               rec_end = 1'b1;
            end
         end
         PH_DONE: begin
            emit = 1'b1;
            kind = FK_NONE;
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase

      // A record closes: count it off in its own section.
      if (rec_end) begin
         for (int i = 0; i < 4; i++) begin
            if (sec == 3'(i + 1)) begin
               remain_in[i] = remain_ff[i] - 16'd1;
               hit_one      = hit_one | (remain_ff[i] == 16'd1);
            end
         end
         record_in = hit_one ? 16'd0 : record_ff + 16'd1;
         fin_chk   = 1'b1;
      end

      // Either another name starts or the message is complete.
      if (fin_chk) begin
         for (int i = 0; i < 4; i++) begin
            any_left = any_left | (remain_in[i] != '0);
         end
         if (any_left) begin
            phase_in      = PH_LEN;
            label_cnt_in  = '0;
            label_left_in = '0;
            bwf_in        = 2'd0;
         end else begin
            phase_in = PH_DONE;
         end
      end

      if (phase_ff == PH_DONE) begin
         status = ST_TRAILING;
      end else if (phase_in == PH_DONE) begin
         status = ST_COMPLETE;
      end else if (req_tlast) begin
         status = ST_TRUNCATED;
      end else begin
         status = ST_PARSING;
      end

      if (!emit && status != ST_PARSING) begin
         emit  = 1'b1;
         kind  = FK_NONE;
         value = '0;
      end

      // The end of the buffer always restarts the parse.
      if (req_tlast) begin
         phase_in      = PH_ID;
         bwf_in        = '0;
         acc_in        = '0;
         record_in     = '0;
         label_left_in = '0;
         label_cnt_in  = '0;
         rdata_left_in = '0;
         for (int i = 0; i < 4; i++) begin
            remain_in[i] = '0;
         end
      end
   end

   assign push      = fire && emit;
   assign push_desc = '{flags: is_flags, kind: kind, value: value, section: sec,
                        record: rec, status: status};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_ID;
         bwf_ff        <= '0;
         acc_ff        <= '0;
         record_ff     <= '0;
         label_left_ff <= '0;
         label_cnt_ff  <= '0;
         rdata_left_ff <= '0;
         for (int i = 0; i < 4; i++) begin
            remain_ff[i] <= '0;
         end
      end else if (fire) begin
         phase_ff      <= phase_in;
         bwf_ff        <= bwf_in;
         acc_ff        <= acc_in;
         record_ff     <= record_in;
         label_left_ff <= label_left_in;
         label_cnt_ff  <= label_cnt_in;
         rdata_left_ff <= rdata_left_in;
         remain_ff     <= remain_in;
      end
   end

   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      fire && req_tlast |=> phase_ff == PH_ID && bwf_ff == 2'd0)
      else $error("parse did not restart after the final byte");

   a_body_has_section: assert property (@(posedge clock) disable iff (reset)
      in_records |-> sec != SEC_HEADER)
      else $error("name or record phase with no section left");

endmodule

// ----- sv/dmsp_back.sv -----
// ============================================================================
// Result expander
// Takes descriptors from the queue and drives the registered result stream,
// spreading a flag descriptor over eight results.
// ============================================================================
module dmsp_back import dmsp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  desc_type               q_head,
   input  logic                   q_empty,
   output logic                   q_pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [4:0]             rsp_tuser,
   output logic                   rsp_tlast
);

   logic [2:0]       sub_ff, sub_in;
   logic             valid_ff, valid_in;
   field_kind_type   kind_ff, kind_in;
   logic [31:0]      value_ff, value_in;
   logic [2:0]       section_ff;
   logic [15:0]      record_ff;
   parse_status_type status_ff;
   logic             last_ff, last_in;
   logic             advance, take;
   logic [7:0]       hi, lo;

   assign advance = !valid_ff || rsp_tready;
   assign take    = advance && !q_empty;
   assign hi      = q_head.value[15:8];
   assign lo      = q_head.value[7:0];
   assign q_pop   = take && (!q_head.flags || sub_ff == FLAG_LAST);

   always_comb begin
      kind_in  = q_head.kind;
      value_in = q_head.value;
      last_in  = 1'b1;
      if (q_head.flags) begin
         last_in = (sub_ff == FLAG_LAST);
         case (sub_ff)
            3'd0: begin
               kind_in  = FK_QR;
               value_in = {31'd0, hi[7]};
            end
            3'd1: begin
               kind_in  = FK_OPCODE;
               value_in = {28'd0, hi[6:3]};
            end
            3'd2: begin
               kind_in  = FK_AA;
               value_in = {31'd0, hi[2]};
            end
            3'd3: begin
               kind_in  = FK_TC;
               value_in = {31'd0, hi[1]};
            end
            3'd4: begin
               kind_in  = FK_RD;
               value_in = {31'd0, hi[0]};
            end
            3'd5: begin
               kind_in  = FK_RA;
               value_in = {31'd0, lo[7]};
            end
            3'd6: begin
               kind_in  = FK_Z;
               value_in = {29'd0, lo[6:4]};
            end
            3'd7: begin
               kind_in  = FK_RCODE;
               value_in = {28'd0, lo[3:0]};
            end
            default: begin
               kind_in  = FK_NONE;
               value_in = '0;
            end
         endcase
      end
      sub_in   = take ? (q_pop ? 3'd0 : sub_ff + 3'd1) : sub_ff;
      valid_in = advance ? !q_empty : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         sub_ff   <= sub_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff    <= kind_in;
         value_ff   <= value_in;
         section_ff <= q_head.section;
         record_ff  <= q_head.record;
         status_ff  <= q_head.status;
         last_ff    <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {3'd0, status_ff, record_ff, section_ff, value_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

   a_flag_expansion_holds_head: assert property (@(posedge clock) disable iff (reset)
      sub_ff != 3'd0 |-> !q_empty && q_head.flags)
      else $error("flag expansion in progress without a flag descriptor at the head");

endmodule

// ----- sv/dns_message_stream_parser.sv -----
// ============================================================================
// DNS message stream parser
// Parses a DNS message arriving one byte per transaction and emits one
// tagged result transaction per completed field, name byte, rdata byte, trailing byte or last byte.
// ============================================================================
// Path: an accepted byte is written into the queue, and the expander moves
//   its first result from the queue head into the output register.
// Throughput: one byte per cycle while the queue has room. The second flag byte
//   yields eight results, one per cycle from the expander while the result side is
//   ready, while the count bytes behind it push a descriptor every other byte; the
//   four-entry queue fills and the input stalls once per message. Every other byte yields at most one.
// Reset: synchronous, active high; clears the parse state, the queue and the
//   output valid flag. There is no clearing pass, so bytes are taken right away.
module dns_message_stream_parser import dmsp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // Input byte channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] data_byte
   input  logic                   req_tlast,   // last_byte
   // Result channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [31:0] field_value,
                                               // [34:32] section_code,
                                               // [50:35] record_number,
                                               // [52:51] parse_status,
                                               // [55:53] zero
   output logic [4:0]             rsp_tuser,   // [4:0] field_kind
   output logic                   rsp_tlast    // run_last
);

   // The classifier pushes at most one descriptor per accepted byte. Bytes
   // that are quiet (the leading bytes of a multi-byte field, the first byte
   // of a compression pointer) push nothing unless they end the buffer.
   logic     push, q_full, q_pop, q_empty;
   desc_type push_desc, q_head;

   dmsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push       (push),
      .push_desc  (push_desc),
      .q_full     (q_full)
   );

   // The queue is what lets the classifier run ahead while the expander
   // spreads the flag word over eight results or the result side stalls.
   dmsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   // The expander owns the output register, so a waiting result never
   // blocks the input side until the queue itself fills.
   dmsp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_head     (q_head),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
